[rtl/core/range_scan_address_sequencer_unit_macros.svh]
// Assertion macros for the range scan address sequencer
`ifndef RANGE_SCAN_ADDRESS_SEQUENCER_UNIT_MACROS_SVH
`define RANGE_SCAN_ADDRESS_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSAS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rsas_pkg.sv]
// Shared types and constants of the range scan address sequencer
package rsas_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PASS_W      = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_RESP = 2'd1;
  localparam logic [1:0] OP_NEXT = 2'd2;

  // bitmap port control
  typedef struct packed {
    logic rd;
    logic wr;
  } bm_ctrl_t;

endpackage

[rtl/core/rsas_bitmap.sv]
// Done bitmap: single-port memory with a clearing sweep after reset
module rsas_bitmap import rsas_pkg::*; #(
  parameter int unsigned MAX_HOSTS = 4096,
  localparam int unsigned AW = $clog2(MAX_HOSTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bm_ctrl_t      ctrl_i,
  input  logic [AW-1:0] addr_i,
  output logic          rd_data_o,
  output logic          busy_o
);

  logic          mem_q [MAX_HOSTS];
  logic          rd_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_HOSTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // bits are only ever set by requests; the sweep zeroes them
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= 1'b0;
    end else if (ctrl_i.wr) begin
      mem_q[addr_i] <= 1'b1;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_busy_q;

endmodule

[rtl/core/range_scan_address_sequencer_unit.sv]
// Range scan address sequencer: range table, done bitmap and scan cursor
//
// Requests enter on the s_axis channel: tuser carries the operation (add range,
// response received, next scan address), tdata the address and the range's last
// address. One result per request leaves on m_axis, held in an output register,
// so a new request is taken while a result still waits for the receiver.
// pass_count is written through cfg_wr_en_i/cfg_wr_data_i and reloads the
// passes left.
// Path from acceptance to a valid result: add runs ST_ADD_SUB, ST_ADD_CHK,
// ST_RESULT; response walks the stored ranges in ST_RS_SCAN, then runs
// ST_RS_RD, ST_RS_CHK when a range holds the address, then ST_RESULT; next
// runs ST_NX_TOP, ST_NX_CHK per host examined, ST_NX_TOP per pass rewind,
// then ST_RESULT. One request is worked at a time.
// After reset the done bitmap is swept clear, one bit per cycle, and
// s_axis_tready_o stays low until the sweep ends. A stalled receiver keeps
// the result in the output register; a finished request then waits before it
// and no new request is taken.
`include "range_scan_address_sequencer_unit_macros.svh"

module range_scan_address_sequencer_unit import rsas_pkg::*; #(
  parameter int unsigned MAX_RANGES = 8,
  parameter int unsigned MAX_HOSTS  = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [PASS_W-1:0]      cfg_wr_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // address [31:0], range_last [63:32]
  input  logic [1:0]             s_axis_tuser_i,   // operation [1:0]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // add_accepted [0], show_response [1], found [2], scan_address [34:3], zero [39:35]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned RCNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned HIDX_W = $clog2(MAX_HOSTS);
  localparam int unsigned HCNT_W = $clog2(MAX_HOSTS + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ADD_SUB = 4'd1;
  localparam logic [3:0] ST_ADD_CHK = 4'd2;
  localparam logic [3:0] ST_RS_SCAN = 4'd3;
  localparam logic [3:0] ST_RS_RD   = 4'd4;
  localparam logic [3:0] ST_RS_CHK  = 4'd5;
  localparam logic [3:0] ST_NX_TOP  = 4'd6;
  localparam logic [3:0] ST_NX_CHK  = 4'd7;
  localparam logic [3:0] ST_RESULT  = 4'd8;

  typedef struct packed {
    logic [ADDR_W-1:0] scan;
    logic              found;
    logic              show;
    logic              add;
  } res_t;

  // range table
  logic [ADDR_W-1:0] start_q [MAX_RANGES];
  logic [HCNT_W-1:0] hosts_q [MAX_RANGES];
  logic [HIDX_W-1:0] base_q  [MAX_RANGES];
  logic              tbl_we;

  logic [3:0]        state_q, state_d;
  logic [RCNT_W-1:0] cnt_q, cnt_d;
  logic [HCNT_W-1:0] used_q, used_d;
  logic              pass_act_q, pass_act_d;
  logic              fresh_q, fresh_d;
  logic [RCNT_W-1:0] cr_q, cr_d;
  logic [HIDX_W-1:0] ch_q, ch_d;
  logic [PASS_W-1:0] passes_q, passes_d;
  logic [RCNT_W-1:0] r_q, r_d;
  logic [HIDX_W-1:0] off_q, off_d;
  logic [HIDX_W-1:0] bit_q, bit_d;
  logic [ADDR_W:0]   diff_q, diff_d;
  logic [ADDR_W-1:0] in_addr_q, in_addr_d;
  logic [ADDR_W-1:0] in_last_q, in_last_d;
  logic [ADDR_W-1:0] cand_q, cand_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [RIDX_W-1:0] cr_idx, r_idx, cnt_idx;
  logic [HCNT_W-1:0] free_bits, hosts_new, ch_nx;
  logic [ADDR_W-1:0] rs_off;
  logic              rs_match;
  logic [RCNT_W-1:0] cr_inc;

  bm_ctrl_t          bm_ctrl;
  logic [HIDX_W-1:0] bm_addr;
  logic              bm_rdata;
  logic              bm_busy;

  rsas_bitmap #(
    .MAX_HOSTS (MAX_HOSTS)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (bm_ctrl),
    .addr_i    (bm_addr),
    .rd_data_o (bm_rdata),
    .busy_o    (bm_busy)
  );

  assign cr_idx  = cr_q[RIDX_W-1:0];
  assign r_idx   = r_q[RIDX_W-1:0];
  assign cnt_idx = cnt_q[RIDX_W-1:0];

  assign free_bits = HCNT_W'(MAX_HOSTS) - used_q;
  assign hosts_new = diff_q[HCNT_W-1:0] + HCNT_W'(1);
  assign ch_nx     = HCNT_W'(ch_q) + HCNT_W'(1);
  assign cr_inc    = cr_q + RCNT_W'(1);

  // one range compare per cycle
  assign rs_off   = in_addr_q - start_q[r_idx];
  assign rs_match = (in_addr_q >= start_q[r_idx]) && (rs_off < ADDR_W'(hosts_q[r_idx]));

  assign s_axis_tready_o = (state_q == ST_IDLE) && !bm_busy;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    pass_act_d  = pass_act_q;
    fresh_d     = fresh_q;
    cr_d        = cr_q;
    ch_d        = ch_q;
    passes_d    = passes_q;
    r_d         = r_q;
    off_d       = off_q;
    bit_d       = bit_q;
    diff_d      = diff_q;
    in_addr_d   = in_addr_q;
    in_last_d   = in_last_q;
    cand_d      = cand_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    tbl_we      = 1'b0;
    bm_ctrl     = '0;
    bm_addr     = '0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          in_addr_d = s_axis_tdata_i[ADDR_W-1:0];
          in_last_d = s_axis_tdata_i[IN_TDATA_W-1:ADDR_W];
          res_d     = '0;
          r_d       = '0;
          fresh_d   = 1'b0;
          case (s_axis_tuser_i)
            OP_ADD:  state_d = ST_ADD_SUB;
            OP_RESP: state_d = ST_RS_SCAN;
            OP_NEXT: state_d = ST_NX_TOP;
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_ADD_SUB: begin
        diff_d  = {1'b0, in_last_q} - {1'b0, in_addr_q};
        state_d = ST_ADD_CHK;
      end
      ST_ADD_CHK: begin
        // borrow means a reversed range
        if (!diff_q[ADDR_W] && (cnt_q < RCNT_W'(MAX_RANGES)) &&
            (diff_q[ADDR_W-1:0] < ADDR_W'(free_bits))) begin
          tbl_we    = 1'b1;
          used_d    = used_q + hosts_new;
          cnt_d     = cnt_q + RCNT_W'(1);
          res_d.add = 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_RS_SCAN: begin
        if (r_q >= cnt_q) begin
          res_d.show = 1'b1;
          state_d    = ST_RESULT;
        end else if (rs_match) begin
          off_d   = rs_off[HIDX_W-1:0];
          state_d = ST_RS_RD;
        end else begin
          r_d = r_q + RCNT_W'(1);
        end
      end
      ST_RS_RD: begin
        bm_addr    = base_q[r_idx] + off_q;
        bm_ctrl.rd = 1'b1;
        bit_d      = bm_addr;
        state_d    = ST_RS_CHK;
      end
      ST_RS_CHK: begin
        bm_addr = bit_q;
        if (!bm_rdata) begin
          bm_ctrl.wr = 1'b1;
          res_d.show = 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_NX_TOP: begin
        if (cnt_q == '0) begin
          state_d = ST_RESULT;
        end else if (!pass_act_q) begin
          if (fresh_q) begin
            // a full pass in this request found nothing: later ones cannot either
            passes_d = '0;
            state_d  = ST_RESULT;
          end else if (passes_q == '0) begin
            state_d = ST_RESULT;
          end else begin
            passes_d   = passes_q - PASS_W'(1);
            pass_act_d = 1'b1;
            cr_d       = '0;
            ch_d       = '0;
            fresh_d    = 1'b1;
          end
        end else if (cr_q >= cnt_q) begin
          pass_act_d = 1'b0;
        end else begin
          bm_addr    = base_q[cr_idx] + ch_q;
          bm_ctrl.rd = 1'b1;
          cand_d     = start_q[cr_idx] + ADDR_W'(ch_q);
          state_d    = ST_NX_CHK;
        end
      end
      ST_NX_CHK: begin
        if (ch_nx >= hosts_q[cr_idx]) begin
          cr_d = cr_inc;
          ch_d = '0;
          if (cr_inc >= cnt_q) begin
            pass_act_d = 1'b0;
          end
        end else begin
          ch_d = ch_nx[HIDX_W-1:0];
        end
        if (!bm_rdata) begin
          res_d.found = 1'b1;
          res_d.scan  = cand_q;
          state_d     = ST_RESULT;
        end else begin
          state_d = ST_NX_TOP;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr_en_i) begin
      passes_d = cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      used_q      <= '0;
      pass_act_q  <= 1'b0;
      fresh_q     <= 1'b0;
      cr_q        <= '0;
      ch_q        <= '0;
      passes_q    <= PASS_W'(1);
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      pass_act_q  <= pass_act_d;
      fresh_q     <= fresh_d;
      cr_q        <= cr_d;
      ch_q        <= ch_d;
      passes_q    <= passes_d;
      r_q         <= r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q     <= off_d;
    bit_q     <= bit_d;
    diff_q    <= diff_d;
    in_addr_q <= in_addr_d;
    in_last_q <= in_last_d;
    cand_q    <= cand_d;
    res_q     <= res_d;
    out_q     <= out_d;
    if (tbl_we) begin
      start_q[cnt_idx] <= in_addr_q;
      hosts_q[cnt_idx] <= hosts_new;
      base_q[cnt_idx]  <= used_q[HIDX_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);

  `RSAS_ASSERT_IMPL(a_table_bounds, 1'b1,
    (cnt_q <= RCNT_W'(MAX_RANGES)) && (used_q <= HCNT_W'(MAX_HOSTS)),
    "range table or bitmap allocation beyond its size")
  `RSAS_ASSERT_IMPL(a_no_access_in_sweep, bm_busy, !bm_ctrl.rd && !bm_ctrl.wr,
    "bitmap request during clearing sweep")
  `RSAS_ASSERT_IMPL(a_cursor_in_range, pass_act_q && (cr_q < cnt_q),
    HCNT_W'(ch_q) < hosts_q[cr_idx], "scan cursor beyond its range")
  `RSAS_ASSERT_NEXT(a_request_leaves_idle, s_axis_tvalid_i && s_axis_tready_o,
    state_q != ST_IDLE, "accepted request not started")

endmodule

[tb/tb_range_scan_address_sequencer_unit.sv]
// Self-checking testbench for the range scan address sequencer
module tb_range_scan_address_sequencer_unit import rsas_pkg::*; ();

  localparam int unsigned TABLE_DEPTH     = 8;
  localparam int unsigned BITMAP_SIZE     = 4096;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned END_SETTLE      = 64;
  localparam int unsigned TIMEOUT_CYCLES  = 2_000_000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] scan_address;
    logic        found;
    logic        show_response;
    logic        add_accepted;
  } scan_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [1:0]   op;
    logic [31:0]  addr;   // pass count for ROW_CFG
    logic [31:0]  last;
    logic         typed;
    scan_result_t want;
  } step_t;

  localparam scan_result_t RES_NONE = '0;
  localparam scan_result_t RES_ADD_OK = '{scan_address: 32'h0, found: 1'b0,
                                          show_response: 1'b0, add_accepted: 1'b1};
  localparam scan_result_t RES_SHOWN = '{scan_address: 32'h0, found: 1'b0,
                                         show_response: 1'b1, add_accepted: 1'b0};

  localparam int unsigned NUM_STEPS = 29;
  localparam step_t DIRECTED_STEPS [NUM_STEPS] = '{
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b1, RES_NONE},   // empty table
    '{ROW_REQ, OP_RESP,   32'h12345678, 32'h0,        1'b1, RES_SHOWN},  // no range holds it
    '{ROW_REQ, OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, RES_NONE},
    '{ROW_REQ, OP_ADD,    32'h5,        32'h4,        1'b1, RES_NONE},   // reversed
    '{ROW_REQ, OP_ADD,    32'h0,        32'hFFFFFFFF, 1'b1, RES_NONE},   // far too wide
    '{ROW_REQ, OP_ADD,    32'h0,        32'h1000,     1'b1, RES_NONE},   // one past bitmap
    '{ROW_REQ, OP_ADD,    32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, RES_ADD_OK},
    '{ROW_REQ, OP_RESP,   32'hFFFFFFFF, 32'h0,        1'b1, RES_SHOWN},
    '{ROW_REQ, OP_RESP,   32'hFFFFFFFF, 32'h0,        1'b1, RES_NONE},   // repeat
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_CFG, OP_ADD,    32'hFFFF,     32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_ADD,    32'h0,        32'h0,        1'b1, RES_ADD_OK},
    '{ROW_REQ, OP_ADD,    32'h0,        32'h7,        1'b1, RES_ADD_OK}, // overlaps
    '{ROW_REQ, OP_RESP,   32'h0,        32'h0,        1'b1, RES_SHOWN},
    '{ROW_REQ, OP_RESP,   32'h0,        32'h0,        1'b1, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_ADD,    32'h80000000, 32'h80000003, 1'b1, RES_ADD_OK}, // mid-pass
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_CFG, OP_ADD,    32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_CFG, OP_ADD,    32'h2,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_NEXT,   32'h0,        32'h0,        1'b0, RES_NONE},
    '{ROW_REQ, OP_RESP,   32'h7,        32'h0,        1'b0, RES_NONE}
  };

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [PASS_W-1:0]      cfg_wr_data = '0;
  logic                   s_tvalid    = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata     = '0;   // address [31:0], range_last [63:32]
  logic [1:0]             s_tuser     = '0;   // operation [1:0]
  logic                   m_tvalid;
  logic                   m_tready    = 1'b0;
  // add_accepted [0], show_response [1], found [2], scan_address [34:3], zero [39:35]
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;

  // mirror of the block state
  logic [31:0] tbl_start [TABLE_DEPTH];
  logic [12:0] tbl_hosts [TABLE_DEPTH];
  logic [11:0] tbl_base  [TABLE_DEPTH];
  bit          host_done [BITMAP_SIZE];
  logic [3:0]  n_ranges    = '0;
  logic [12:0] n_bits_used = '0;
  logic        pass_on     = 1'b0;
  logic [3:0]  cur_range   = '0;
  logic [12:0] cur_host    = '0;
  logic [15:0] passes_left = 16'd1;

  scan_result_t pending_results [$];
  int unsigned  fail_count   = 0;
  int unsigned  requests_run = 0;
  int unsigned  adds_stored  = 0;
  int unsigned  repeats_seen = 0;
  int unsigned  scans_issued = 0;
  int unsigned  scans_empty  = 0;

  range_scan_address_sequencer_unit #(
    .MAX_RANGES(TABLE_DEPTH),
    .MAX_HOSTS (BITMAP_SIZE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Verification failed");
    $finish;
  end

  function automatic logic store_range(logic [31:0] first, logic [31:0] last);
    logic [32:0] span;
    span = {1'b0, last} - {1'b0, first} + 33'd1;
    if (last < first) return 1'b0;
    if (n_ranges >= TABLE_DEPTH) return 1'b0;
    if (span > 33'(BITMAP_SIZE) - 33'(n_bits_used)) return 1'b0;
    tbl_start[n_ranges] = first;
    tbl_hosts[n_ranges] = span[12:0];
    tbl_base[n_ranges]  = n_bits_used[11:0];
    n_bits_used = n_bits_used + span[12:0];
    n_ranges    = n_ranges + 4'd1;
    return 1'b1;
  endfunction

  // first range holding the host wins; 0 only for a host already done
  function automatic logic mark_host(logic [31:0] host);
    logic [31:0] off;
    int unsigned slot;
    for (int r = 0; r < n_ranges; r++) begin
      off = host - tbl_start[r];
      if (host >= tbl_start[r] && off < tbl_hosts[r]) begin
        slot = tbl_base[r] + off;
        if (slot >= BITMAP_SIZE) return 1'b1;
        if (host_done[slot]) return 1'b0;
        host_done[slot] = 1'b1;
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic advance_cursor(output logic [31:0] scan);
    logic        walking;
    logic        pass_began_here;
    logic        hit;
    int unsigned slot;
    scan            = '0;
    hit             = 1'b0;
    pass_began_here = 1'b0;
    walking         = (n_ranges != 0);
    while (walking) begin
      if (!pass_on) begin
        // a full pass that found nothing burns every remaining pass
        if (pass_began_here) begin
          passes_left = '0;
          walking     = 1'b0;
        end else if (passes_left == 0) begin
          walking = 1'b0;
        end else begin
          passes_left     = passes_left - 16'd1;
          pass_on         = 1'b1;
          cur_range       = '0;
          cur_host        = '0;
          pass_began_here = 1'b1;
        end
      end else if (cur_range >= n_ranges) begin
        pass_on = 1'b0;
      end else begin
        slot = tbl_base[cur_range] + cur_host;
        if (slot < BITMAP_SIZE && !host_done[slot]) begin
          scan    = tbl_start[cur_range] + cur_host;
          hit     = 1'b1;
          walking = 1'b0;
        end
        cur_host = cur_host + 13'd1;
        if (cur_host >= tbl_hosts[cur_range]) begin
          cur_range = cur_range + 4'd1;
          cur_host  = '0;
          if (cur_range >= n_ranges) pass_on = 1'b0;
        end
      end
    end
    return hit;
  endfunction

  function automatic scan_result_t predict_result(logic [1:0] op, logic [31:0] addr,
                                                  logic [31:0] last);
    scan_result_t res;
    logic [31:0]  scan;
    res = '0;
    case (op)
      OP_ADD:  res.add_accepted  = store_range(addr, last);
      OP_RESP: res.show_response = mark_host(addr);
      OP_NEXT: begin
        res.found = advance_cursor(scan);
        if (res.found) res.scan_address = scan;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // random request shaped by the mirrored table so that most hit real ranges
  function automatic void pick_request(output logic [1:0] op, output logic [31:0] addr,
                                       output logic [31:0] last);
    int unsigned roll;
    int unsigned size;
    int unsigned r;
    int unsigned room;
    roll = $urandom_range(0, 99);
    addr = $urandom;
    last = $urandom;
    room = BITMAP_SIZE - n_bits_used;
    if (roll < 14) begin
      op   = OP_ADD;
      roll = $urandom_range(0, 99);
      if (roll < 45)      size = $urandom_range(1, 16);
      else if (roll < 70) size = $urandom_range(17, 300);
      else if (roll < 80) size = (room == 0) ? 1 : room;
      else if (roll < 88) size = room + 1;
      else                size = 0;   // raw fields: mostly reversed or oversized
      if (size != 0) begin
        if (n_ranges != 0 && $urandom_range(0, 3) == 0) begin
          r    = $urandom_range(0, n_ranges - 1);
          addr = tbl_start[r] + $urandom_range(0, tbl_hosts[r] - 1);
        end
        if (addr > 32'hFFFFFFFF - (size - 1)) addr = 32'hFFFFFFFF - (size - 1);
        last = addr + size - 1;
      end
    end else if (roll < 50) begin
      op   = OP_RESP;
      roll = $urandom_range(0, 9);
      if (n_ranges != 0 && roll < 9) begin
        r = $urandom_range(0, n_ranges - 1);
        if (roll < 7)       addr = tbl_start[r] + $urandom_range(0, tbl_hosts[r] - 1);
        else if (roll == 7) addr = tbl_start[r] - 1;
        else                addr = tbl_start[r] + tbl_hosts[r];
      end
    end else if (roll < 96) begin
      op = OP_NEXT;
    end else begin
      op = OP_UNUSED;
    end
  endfunction

  task automatic offer_request(input logic [1:0] op, input logic [31:0] addr,
                               input logic [31:0] last, input logic typed,
                               input scan_result_t want);
    scan_result_t predicted;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {last, addr};
    do @(posedge clk_i); while (!s_tready);
    predicted = predict_result(op, addr, last);
    pending_results.push_back(typed ? want : predicted);
    requests_run++;
    if (op == OP_RESP && !predicted.show_response) repeats_seen++;
    if (op == OP_NEXT && !predicted.found) scans_empty++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pass_count(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
    passes_left = value;
  endtask

  initial begin : stimulus
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] last;
    logic [15:0] passes;
    int unsigned burst_left;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == ROW_CFG) begin
        drain_results();
        write_pass_count(DIRECTED_STEPS[i].addr[15:0]);
      end else begin
        offer_request(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].addr, DIRECTED_STEPS[i].last,
                      DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       passes = 16'd1;
        1:       passes = 16'hFFFF;
        2:       passes = 16'd0;
        3:       passes = 16'd3;
        4:       passes = 16'($urandom_range(4, 65535));
        default: passes = 16'd2;
      endcase
      drain_results();
      write_pass_count(passes);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
          burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
        end
        if (ph == 1 && n == 40) hold_off_req = 1'b1;
        pick_request(op, addr, last);
        offer_request(op, addr, last, 1'b0, RES_NONE);
        burst_left--;
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("Ran %0d requests: %0d ranges stored using %0d bitmap bits, %0d adds taken.",
             requests_run, n_ranges, n_bits_used, adds_stored);
    $display("Responses repeated %0d times; %0d scan addresses issued, %0d scans empty.",
             repeats_seen, scans_issued, scans_empty);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // long stall so the output register and the worker back up into s_axis
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 48);
        repeat (span) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    scan_result_t want;
    scan_result_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[34:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.add_accepted !== want.add_accepted) begin
          $error("add_accepted: expected %0d, got %0d", want.add_accepted, got.add_accepted);
          fail_count++;
        end
        if (got.show_response !== want.show_response) begin
          $error("show_response: expected %0d, got %0d", want.show_response,
                 got.show_response);
          fail_count++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          fail_count++;
        end
        if (got.scan_address !== want.scan_address) begin
          $error("scan_address: expected %h, got %h", want.scan_address, got.scan_address);
          fail_count++;
        end
        if (want.add_accepted) adds_stored++;
        if (want.found) scans_issued++;
      end
    end
  end

endmodule
